[rtl/sled_pkg.sv]
// ----------------------------------------------------------------------------
// sled_pkg
// Shared types and constants of the string literal escape decoder.
// ----------------------------------------------------------------------------
package sled_pkg;

    // default depth of the result queue
    localparam int FIFO_DEPTH = 4;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_V      = 8'h76;

    // control codes produced by letter escapes
    localparam logic [7:0] CC_BS  = 8'd8;
    localparam logic [7:0] CC_TAB = 8'd9;
    localparam logic [7:0] CC_LF  = 8'd10;
    localparam logic [7:0] CC_VT  = 8'd11;
    localparam logic [7:0] CC_FF  = 8'd12;
    localparam logic [7:0] CC_CR  = 8'd13;

    // result kinds
    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    // decoder state
    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_OCT  = 2'd2
    } mode_t;

    // one result item
    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      kind;
        logic       last;
    } result_t;

    // results produced by one input item, handed to the queue
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

    function automatic result_t make_res(input logic [7:0] b, input kind_t k);
        result_t r;
        r.out_byte = b;
        r.kind     = k;
        r.last     = (k != KIND_DATA);
        return r;
    endfunction

endpackage

[rtl/sled_decode.sv]
// ----------------------------------------------------------------------------
// sled_decode
// Input register, escape state and single-pass decode of one byte into
// zero, one or two results.
// ----------------------------------------------------------------------------
module sled_decode (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      in_byte,
    input  logic            space_ok,
    output sled_pkg::push_t push
);

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    sled_pkg::mode_t     mode_reg;
    sled_pkg::mode_t     mode_next;
    logic [7:0]          acc_reg;
    logic [7:0]          acc_next;
    logic                advance;
    logic [1:0]          res_cnt;
    sled_pkg::result_t   res0;
    sled_pkg::result_t   res1;
    logic                is_digit;
    logic                is_oct;
    logic                text_hit;
    sled_pkg::result_t   text_res;

    // handshake
    assign advance  = in_valid_reg && space_ok;
    assign in_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            in_byte_reg <= in_byte;
        end
    end

    // character classes
    assign is_digit = (in_byte_reg >= sled_pkg::CH_0) && (in_byte_reg <= sled_pkg::CH_9);
    assign is_oct   = (in_byte_reg >= sled_pkg::CH_0) && (in_byte_reg <= sled_pkg::CH_7);

    // byte handled as plain text
    always_comb begin
        text_hit = 1'b1;
        if (in_byte_reg == sled_pkg::CH_QUOTE) begin
            text_res = sled_pkg::make_res(8'h00, sled_pkg::KIND_END);
        end else if (in_byte_reg == sled_pkg::CH_NUL) begin
            text_res = sled_pkg::make_res(8'h00, sled_pkg::KIND_ERR);
        end else begin
            text_res = sled_pkg::make_res(in_byte_reg, sled_pkg::KIND_DATA);
            text_hit = (in_byte_reg != sled_pkg::CH_BSLASH);
        end
    end

    // next state
    always_comb begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        unique case (mode_reg)
            sled_pkg::MODE_ESC: begin
                if (in_byte_reg == sled_pkg::CH_NUL) begin
                    mode_next = sled_pkg::MODE_TEXT;
                end else if (is_digit) begin
                    acc_next  = 8'(in_byte_reg - sled_pkg::CH_0);
                    mode_next = sled_pkg::MODE_OCT;
                end else begin
                    mode_next = sled_pkg::MODE_TEXT;
                end
            end
            sled_pkg::MODE_OCT: begin
                if (is_oct) begin
                    acc_next = {acc_reg[4:0], 3'b000} + {5'b00000, in_byte_reg[2:0]};
                end else begin
                    acc_next  = 8'h00;
                    mode_next = (in_byte_reg == sled_pkg::CH_BSLASH) ?
                                sled_pkg::MODE_ESC : sled_pkg::MODE_TEXT;
                end
            end
            default: begin
                mode_next = (in_byte_reg == sled_pkg::CH_BSLASH) ?
                            sled_pkg::MODE_ESC : sled_pkg::MODE_TEXT;
            end
        endcase
    end

    // results of the current byte
    always_comb begin
        res_cnt = 2'd0;
        res0    = sled_pkg::make_res(8'h00, sled_pkg::KIND_DATA);
        res1    = sled_pkg::make_res(8'h00, sled_pkg::KIND_DATA);
        unique case (mode_reg)
            sled_pkg::MODE_ESC: begin
                if (in_byte_reg == sled_pkg::CH_NUL) begin
                    res_cnt = 2'd1;
                    res0    = sled_pkg::make_res(8'h00, sled_pkg::KIND_ERR);
                end else if (!is_digit) begin
                    res_cnt = 2'd1;
                    unique case (in_byte_reg) inside
                        sled_pkg::CH_BSLASH, sled_pkg::CH_APOS, sled_pkg::CH_QUOTE:
                            res0 = sled_pkg::make_res(in_byte_reg, sled_pkg::KIND_DATA);
                        sled_pkg::CH_B: res0 = sled_pkg::make_res(sled_pkg::CC_BS,
                                                                  sled_pkg::KIND_DATA);
                        sled_pkg::CH_F: res0 = sled_pkg::make_res(sled_pkg::CC_FF,
                                                                  sled_pkg::KIND_DATA);
                        sled_pkg::CH_N: res0 = sled_pkg::make_res(sled_pkg::CC_LF,
                                                                  sled_pkg::KIND_DATA);
                        sled_pkg::CH_R: res0 = sled_pkg::make_res(sled_pkg::CC_CR,
                                                                  sled_pkg::KIND_DATA);
                        sled_pkg::CH_T: res0 = sled_pkg::make_res(sled_pkg::CC_TAB,
                                                                  sled_pkg::KIND_DATA);
                        sled_pkg::CH_V: res0 = sled_pkg::make_res(sled_pkg::CC_VT,
                                                                  sled_pkg::KIND_DATA);
                        default: begin
                            // unknown escape keeps its backslash
                            res_cnt = 2'd2;
                            res0    = sled_pkg::make_res(sled_pkg::CH_BSLASH,
                                                         sled_pkg::KIND_DATA);
                            res1    = sled_pkg::make_res(in_byte_reg, sled_pkg::KIND_DATA);
                        end
                    endcase
                end
            end
            sled_pkg::MODE_OCT: begin
                if (!is_oct) begin
                    // octal value first, then the byte as plain text
                    res0    = sled_pkg::make_res(acc_reg, sled_pkg::KIND_DATA);
                    res1    = text_res;
                    res_cnt = text_hit ? 2'd2 : 2'd1;
                end
            end
            default: begin
                res0    = text_res;
                res_cnt = text_hit ? 2'd1 : 2'd0;
            end
        endcase
    end

    // escape state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= sled_pkg::MODE_TEXT;
            acc_reg  <= 8'h00;
        end else if (advance) begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
        end
    end

    // results toward the queue
    assign push.count = advance ? res_cnt : 2'd0;
    assign push.res0  = res0;
    assign push.res1  = res1;

`ifndef SYNTHESIS
    // never more than two results per byte
    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd3)
        else $error("sled_decode: push count out of range");

    // with two results the first is always a data byte
    a_two_first_data: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count == 2'd2 |-> push.res0.kind == sled_pkg::KIND_DATA)
        else $error("sled_decode: first of two results is not data");

    // a held byte stays in the input register
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("sled_decode: held byte lost");

    // the escape state moves only when a byte is consumed
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance && $past(aresetn) |=> $stable(mode_reg) && $stable(acc_reg))
        else $error("sled_decode: state changed without a byte");
`endif

endmodule

[rtl/sled_result_fifo.sv]
// ----------------------------------------------------------------------------
// sled_result_fifo
// Small result queue: takes up to two results per cycle, hands out one while out_ready is high.
// ----------------------------------------------------------------------------
module sled_result_fifo #(
    parameter int DEPTH = sled_pkg::FIFO_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  sled_pkg::push_t   push,
    output logic              space_ok,
    output logic              out_valid,
    input  logic              out_ready,
    output sled_pkg::result_t out_res
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sled_pkg::result_t  mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_p1;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // room for two results
    assign space_ok  = (count_reg <= CNT_W'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_res   = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // pointer and fill arithmetic
    assign wr_ptr_p1 = ptr_inc(wr_ptr_reg);
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        if (push.count == 2'd1) begin
            wr_ptr_next = wr_ptr_p1;
        end else if (push.count == 2'd2) begin
            wr_ptr_next = ptr_inc(wr_ptr_p1);
        end
        count_next = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.count == 2'd2) begin
            mem[wr_ptr_p1] <= push.res1;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
        end
    end

`ifndef SYNTHESIS
    // results arrive only when there was room for two
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd0 |-> space_ok)
        else $error("sled_result_fifo: push without room");

    // fill never passes the depth
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("sled_result_fifo: fill beyond depth");

    // a pop with no push drops the fill by one
    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && push.count == 2'd0 && aresetn |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("sled_result_fifo: fill not decremented");
`endif

endmodule

[rtl/string_literal_escape_decoder_top.sv]
// path: input register, then the result queue once it has room for two results
// throughput: one byte per cycle while there is room; two results leave in turn
// the four-entry result queue takes bytes while earlier results still wait
// reset: synchronous, active low; clears the escape state and the queue
// ----------------------------------------------------------------------------
// string_literal_escape_decoder_top
// Decodes the bytes of a quoted string body into data, end and error items.
// ----------------------------------------------------------------------------
module string_literal_escape_decoder_top #(
    parameter int FIFO_DEPTH = sled_pkg::FIFO_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic [1:0] m_kind,
    output logic       m_last
);

    sled_pkg::push_t   push;
    sled_pkg::result_t out_res;
    logic              space_ok;

    // decode stage
    sled_decode u_decode (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_byte  (s_in_byte),
        .space_ok (space_ok),
        .push     (push)
    );

    // result queue
    sled_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    // result item fields
    assign m_out_byte = out_res.out_byte;
    assign m_kind     = 2'(out_res.kind);
    assign m_last     = out_res.last;

endmodule

[tb/escape_decode_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// escape_decode_checker
// Watches both channels of the escape decoder, works out the decoded items
// for every accepted byte and compares them in order with the items that
// leave the block. Hands the failure count and the number of items still
// awaited to the testbench top.
// ----------------------------------------------------------------------------
module escape_decode_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte,
    input  logic [1:0] m_kind,
    input  logic       m_last,
    output int         mismatch_count,
    output int         decoded_pending
);

    // predicted items, oldest first
    sled_pkg::result_t decoded_q[$];
    // own copy of the decoder state
    sled_pkg::mode_t   esc_state   = sled_pkg::MODE_TEXT;
    logic [7:0]        octal_value = '0;

    function automatic void expect_result(input logic [7:0] b, input sled_pkg::kind_t k);
        sled_pkg::result_t r;
        r.out_byte = b;
        r.kind     = k;
        r.last     = (k == sled_pkg::KIND_END) || (k == sled_pkg::KIND_ERR);
        decoded_q.push_back(r);
    endfunction

    // byte seen in plain text: quote ends, nul fails, backslash opens an escape
    function automatic void text_byte(input logic [7:0] c);
        esc_state = sled_pkg::MODE_TEXT;
        if (c == sled_pkg::CH_QUOTE) begin
            expect_result(8'h00, sled_pkg::KIND_END);
        end else if (c == sled_pkg::CH_NUL) begin
            expect_result(8'h00, sled_pkg::KIND_ERR);
        end else if (c == sled_pkg::CH_BSLASH) begin
            esc_state = sled_pkg::MODE_ESC;
        end else begin
            expect_result(c, sled_pkg::KIND_DATA);
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] c);
        logic [7:0] digit;
        digit = c - sled_pkg::CH_0;
        case (esc_state)
            sled_pkg::MODE_ESC: begin
                esc_state = sled_pkg::MODE_TEXT;
                if (c == sled_pkg::CH_NUL) begin
                    expect_result(8'h00, sled_pkg::KIND_ERR);
                end else if (c >= sled_pkg::CH_0 && c <= sled_pkg::CH_9) begin
                    // any decimal digit may open an octal value
                    octal_value = digit;
                    esc_state   = sled_pkg::MODE_OCT;
                end else begin
                    case (c)
                        sled_pkg::CH_BSLASH, sled_pkg::CH_APOS, sled_pkg::CH_QUOTE:
                            expect_result(c, sled_pkg::KIND_DATA);
                        sled_pkg::CH_B: expect_result(sled_pkg::CC_BS, sled_pkg::KIND_DATA);
                        sled_pkg::CH_F: expect_result(sled_pkg::CC_FF, sled_pkg::KIND_DATA);
                        sled_pkg::CH_N: expect_result(sled_pkg::CC_LF, sled_pkg::KIND_DATA);
                        sled_pkg::CH_R: expect_result(sled_pkg::CC_CR, sled_pkg::KIND_DATA);
                        sled_pkg::CH_T: expect_result(sled_pkg::CC_TAB, sled_pkg::KIND_DATA);
                        sled_pkg::CH_V: expect_result(sled_pkg::CC_VT, sled_pkg::KIND_DATA);
                        default: begin
                            // unknown escape keeps its backslash
                            expect_result(sled_pkg::CH_BSLASH, sled_pkg::KIND_DATA);
                            expect_result(c, sled_pkg::KIND_DATA);
                        end
                    endcase
                end
            end
            sled_pkg::MODE_OCT: begin
                if (c >= sled_pkg::CH_0 && c <= sled_pkg::CH_7) begin
                    // wraps at 8 bits
                    octal_value = 8'({octal_value, 3'b000} + digit);
                end else begin
                    // value first, then the same byte as plain text
                    expect_result(octal_value, sled_pkg::KIND_DATA);
                    octal_value = '0;
                    text_byte(c);
                end
            end
            default: text_byte(c);
        endcase
    endfunction

    function automatic void log_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s", $time, msg);
        end
    endfunction

    // predict on accepted bytes, compare accepted items with the oldest prediction
    always @(posedge aclk) begin : compare_items
        sled_pkg::result_t want;
        if (!aresetn) begin
            decoded_q.delete();
            esc_state   = sled_pkg::MODE_TEXT;
            octal_value = '0;
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(s_in_byte);
            end
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    log_failure($sformatf("unexpected item: byte %02h kind %0d last %0b",
                                          m_out_byte, m_kind, m_last));
                end else begin
                    want = decoded_q.pop_front();
                    if (m_out_byte !== want.out_byte || m_kind !== want.kind
                            || m_last !== want.last) begin
                        log_failure($sformatf({"item mismatch: expected byte %02h kind %0d ",
                                               "last %0b, got byte %02h kind %0d last %0b"},
                                              want.out_byte, want.kind, want.last,
                                              m_out_byte, m_kind, m_last));
                    end
                end
            end
        end
        decoded_pending = decoded_q.size();
    end

endmodule

[tb/string_literal_escape_decoder_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// string_literal_escape_decoder_top_test
// Feeds quoted string bodies into the escape decoder: a directed run over
// the escape corner cases, then random strings built mostly from plain
// characters and valid escapes with some noise and broken endings. Both
// channels idle at random apart from one steady stretch. The checker beside
// the block judges every item; this module gives the verdict.
// ----------------------------------------------------------------------------
module string_literal_escape_decoder_top_test;

    localparam int STALL_LIMIT = 2000;
    localparam int STREAM_BYTES = 1350;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    logic [7:0] s_in_byte = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    logic [7:0] m_out_byte;
    logic [1:0] m_kind;
    logic       m_last;

    int         fail_count;
    int         decoded_pending;
    int         stall_cycles = 0;
    bit         steady = 1'b0;
    logic [7:0] stream_q[$];
    logic [7:0] esc_letters [9] = '{sled_pkg::CH_BSLASH, sled_pkg::CH_APOS,
                                    sled_pkg::CH_QUOTE, sled_pkg::CH_B, sled_pkg::CH_F,
                                    sled_pkg::CH_N, sled_pkg::CH_R, sled_pkg::CH_T,
                                    sled_pkg::CH_V};

    string_literal_escape_decoder_top i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_byte  (s_in_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_kind     (m_kind),
        .m_last     (m_last)
    );

    escape_decode_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_in_byte       (s_in_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_kind          (m_kind),
        .m_last          (m_last),
        .mismatch_count  (fail_count),
        .decoded_pending (decoded_pending)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // result side backpressure
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 8);
    end

    // give up when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one random string body: mostly well-formed pieces, some noise, a terminator
    task automatic add_random_string();
        int         parts;
        int         pick;
        logic [7:0] b;
        parts = $urandom_range(0, 12);
        repeat (parts) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                do b = 8'($urandom_range(1, 255));
                while (b == sled_pkg::CH_QUOTE || b == sled_pkg::CH_BSLASH);
                stream_q.push_back(b);
            end else if (pick < 75) begin
                stream_q.push_back(sled_pkg::CH_BSLASH);
                stream_q.push_back(esc_letters[$urandom_range(0, 8)]);
            end else if (pick < 85) begin
                // octal escape, first digit may be 8 or 9
                stream_q.push_back(sled_pkg::CH_BSLASH);
                stream_q.push_back(8'(sled_pkg::CH_0 + $urandom_range(0, 9)));
                repeat ($urandom_range(0, 3)) begin
                    stream_q.push_back(8'(sled_pkg::CH_0 + $urandom_range(0, 7)));
                end
            end else if (pick < 92) begin
                // escape of a character with no meaning
                stream_q.push_back(sled_pkg::CH_BSLASH);
                do b = 8'($urandom_range(1, 255));
                while (b inside {[sled_pkg::CH_0:sled_pkg::CH_9], sled_pkg::CH_BSLASH,
                                 sled_pkg::CH_APOS, sled_pkg::CH_QUOTE,
                                 sled_pkg::CH_B, sled_pkg::CH_F, sled_pkg::CH_N,
                                 sled_pkg::CH_R, sled_pkg::CH_T, sled_pkg::CH_V});
                stream_q.push_back(b);
            end else begin
                stream_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            stream_q.push_back(sled_pkg::CH_QUOTE);
        end else if (pick < 95) begin
            stream_q.push_back(sled_pkg::CH_NUL);
        end else begin
            stream_q.push_back(sled_pkg::CH_BSLASH);
            stream_q.push_back(sled_pkg::CH_NUL);
        end
    endtask

    // present one byte and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        if (!steady && $urandom_range(0, 99) < 8) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    initial begin
        // directed: byte extremes, unknown escape, octal wrap ended by a quote,
        // digit 9 opening and 8 closing, nul inside octal, nul after backslash,
        // bare nul, octal ended by a backslash
        stream_q = '{8'h01, 8'hff, sled_pkg::CH_BSLASH, sled_pkg::CH_N,
                     sled_pkg::CH_BSLASH, 8'h71,
                     sled_pkg::CH_BSLASH, sled_pkg::CH_7, sled_pkg::CH_7, sled_pkg::CH_7,
                     sled_pkg::CH_QUOTE,
                     sled_pkg::CH_BSLASH, sled_pkg::CH_9, 8'h38,
                     sled_pkg::CH_BSLASH, sled_pkg::CH_0, sled_pkg::CH_NUL,
                     sled_pkg::CH_BSLASH, sled_pkg::CH_NUL, sled_pkg::CH_NUL,
                     sled_pkg::CH_BSLASH, 8'h31, sled_pkg::CH_BSLASH, sled_pkg::CH_T,
                     sled_pkg::CH_QUOTE};
        while (stream_q.size() < STREAM_BYTES) begin
            add_random_string();
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stream_q[i]) begin
            steady = (i >= 400 && i < 700);
            send_byte(stream_q[i]);
        end
        s_valid <= 1'b0;
        steady = 1'b0;

        // drain, then keep watching for stray items
        do @(negedge aclk);
        while (decoded_pending != 0);
        repeat (10) @(posedge aclk);
        @(negedge aclk);

        if (fail_count == 0 && decoded_pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
